/* rtl/assert_macros.svh */
// Assertion macros shared by the sensor grid debounce RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, masked while rst_ni is low.
`define SGDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define SGDO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/sgdo_pkg.sv */
// Shared types and constants of the sensor grid debounce block.
package sgdo_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoordW  = 3;
  localparam int unsigned BitW    = 6;
  localparam int unsigned BoardW  = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;

  localparam logic [CfgIdxW-1:0] CfgBaseValue    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDetectOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStableTime   = 2'd2;

  localparam logic [CfgW-1:0] BaseValueRst    = 16'd2048;
  localparam logic [CfgW-1:0] DetectOffsetRst = 16'd200;
  localparam logic [CfgW-1:0] StableTimeRst   = 16'd50;

  // One entry of the per-cell store.
  typedef struct packed {
    logic             state;
    logic             stable;
    logic [TimeW-1:0] ctime;
  } cell_t;

  // Result of the per-cell update.
  typedef struct packed {
    cell_t entry;
    logic  settle;  // hold time exceeded: bitmap bit takes entry.state
  } upd_t;

endpackage

/* rtl/sensor_grid_debounce_occupancy.sv */
// Top level of the sensor grid debounce and occupancy bitmap block.
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid/s_axis_tready    one scanned cell sample
//  m_axis    out  m_axis_tvalid/m_axis_tready    raw state, stable mark, bitmap
//  cfg       in   cfg_we_i                       register write, no read-back
//
// One transfer per cycle sustained while m_axis_tready is high; items pass the
// threshold stage, cell memory read with update and write-back, result reg.
// Consecutive items on one cell are served by a write bypass in the memory.
// Reset clears cell state through per-entry valid bits, no clearing pass.
// A stalled output holds one result; one more item waits in the update stage.
`include "assert_macros.svh"

module sensor_grid_debounce_occupancy #(
  parameter int unsigned GRID_SIZE = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: cell_col[2:0], cell_row[5:3], sample[21:6], now_ms[53:22], zero pad
  input  logic [sgdo_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: raw_occupied[0], cell_stable[1], board[65:2], zero pad
  output logic [sgdo_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [sgdo_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sgdo_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int unsigned DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [sgdo_pkg::CoordW:0] GridLim = (sgdo_pkg::CoordW + 1)'(GRID_SIZE);
  localparam logic [sgdo_pkg::BitW-1:0] GridMul = sgdo_pkg::BitW'(GRID_SIZE);

  // configuration
  logic [sgdo_pkg::CfgW-1:0] base_q, offset_q, stime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= sgdo_pkg::BaseValueRst;
      offset_q <= sgdo_pkg::DetectOffsetRst;
      stime_q  <= sgdo_pkg::StableTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgdo_pkg::CfgBaseValue:    base_q   <= cfg_data_i;
        sgdo_pkg::CfgDetectOffset: offset_q <= cfg_data_i;
        sgdo_pkg::CfgStableTime:   stime_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [sgdo_pkg::CoordW-1:0]  in_col, in_row;
  logic [sgdo_pkg::SampleW-1:0] in_sample;
  logic [sgdo_pkg::TimeW-1:0]   in_now;

  assign in_col    = s_axis_tdata[2:0];
  assign in_row    = s_axis_tdata[5:3];
  assign in_sample = s_axis_tdata[21:6];
  assign in_now    = s_axis_tdata[53:22];

  // threshold and address
  logic [sgdo_pkg::SampleW-1:0] diff;
  logic                         raw;
  logic                         in_grid;
  logic [sgdo_pkg::BitW-1:0]    bit_idx;
  logic [AW-1:0]                rd_addr;

  assign diff    = (in_sample >= base_q) ? (in_sample - base_q) : (base_q - in_sample);
  assign raw     = diff > offset_q;
  assign in_grid = ({1'b0, in_col} < GridLim) && ({1'b0, in_row} < GridLim);
  assign bit_idx = ({{(sgdo_pkg::BitW - sgdo_pkg::CoordW){1'b0}}, in_row} * GridMul)
                 + {{(sgdo_pkg::BitW - sgdo_pkg::CoordW){1'b0}}, in_col};
  assign rd_addr = in_grid ? bit_idx[AW-1:0] : '0;

  // pipeline control
  logic s1_vld_q, out_vld_q;
  logic out_free, s1_adv, in_acc;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && out_free;
  assign s_axis_tready = !s1_vld_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // update stage
  logic                       s1_raw_q, s1_grid_q;
  logic [sgdo_pkg::TimeW-1:0] s1_now_q;
  logic [sgdo_pkg::BitW-1:0]  s1_bit_q;
  logic [sgdo_pkg::BoardW-1:0] map_q, map_d, bit_mask;
  sgdo_pkg::cell_t            cur_cell;
  sgdo_pkg::upd_t             upd;
  logic                       wr_en;

  sgdo_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_bit_q[AW-1:0]),
    .wr_data_i (upd.entry),
    .rd_data_o (cur_cell)
  );

  sgdo_update u_update (
    .cur_i         (cur_cell),
    .raw_i         (s1_raw_q),
    .now_i         (s1_now_q),
    .stable_time_i (stime_q),
    .upd_o         (upd)
  );

  assign wr_en    = s1_adv && s1_grid_q;
  assign bit_mask = sgdo_pkg::BoardW'(1) << s1_bit_q;

  always_comb begin
    map_d = map_q;
    if (wr_en && upd.settle) begin
      map_d = upd.entry.state ? (map_q | bit_mask) : (map_q & ~bit_mask);
    end
  end

  // result register
  logic                        out_raw_q, out_stable_q;
  logic [sgdo_pkg::BoardW-1:0] out_board_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      map_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_vld_q <= in_acc;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
      map_q <= map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_raw_q  <= raw;
      s1_grid_q <= in_grid;
      s1_now_q  <= in_now;
      s1_bit_q  <= bit_idx;
    end
    if (s1_adv) begin
      out_raw_q    <= s1_raw_q;
      out_stable_q <= s1_grid_q && upd.entry.stable;
      out_board_q  <= map_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(sgdo_pkg::OutDataW - sgdo_pkg::BoardW - 2){1'b0}},
                          out_board_q, out_stable_q, out_raw_q};

  `SGDO_ASSERT(a_map_needs_write, (map_q != $past(map_q)) |-> $past(wr_en), "bitmap changed without a cell write")
  `SGDO_ASSERT(a_offgrid_unstable, (s1_adv && !s1_grid_q) |=> !out_stable_q, "cell outside grid reported stable")
  `SGDO_ASSERT(a_hold_under_stall, (s1_vld_q && !out_free) |=> (s1_vld_q && $stable(s1_bit_q)), "update stage lost an item while stalled")
  `SGDO_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!m_axis_tvalid && !s1_vld_q), "pipeline valid during reset")

endmodule

/* rtl/sgdo_cell_mem.sv */
// Per-cell state memory with registered read, valid bits and write bypass.
`include "assert_macros.svh"

module sgdo_cell_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  sgdo_pkg::cell_t wr_data_i,
  output sgdo_pkg::cell_t rd_data_o
);

  sgdo_pkg::cell_t mem_q [DEPTH];
  sgdo_pkg::cell_t rd_q;
  sgdo_pkg::cell_t byp_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;
  logic             byp_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem_q[rd_addr_i];
      byp_q <= wr_data_i;
    end
  end

  // Entries never written read as the reset value (all zero).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      byp_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        byp_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = byp_hit_q ? byp_q : (rd_vld_q ? rd_q : '0);

  `SGDO_ASSERT(a_bypass, (rd_en_i && wr_en_i && rd_addr_i == wr_addr_i) |=> (rd_data_o == $past(wr_data_i)), "read beside write of same entry missed the new data")
  `SGDO_ASSERT(a_valid_set, wr_en_i |=> vld_q[$past(wr_addr_i)], "written entry not marked valid")
  `SGDO_ASSERT(a_unwritten_zero, (rd_en_i && !wr_en_i && !vld_q[rd_addr_i]) |=> (rd_data_o == '0), "unwritten entry read nonzero")

endmodule

/* rtl/sgdo_update.sv */
// Per-cell debounce update: change tracking and hold-time check.
module sgdo_update (
  input  sgdo_pkg::cell_t                cur_i,
  input  logic                           raw_i,
  input  logic [sgdo_pkg::TimeW-1:0]     now_i,
  input  logic [sgdo_pkg::CfgW-1:0]      stable_time_i,
  output sgdo_pkg::upd_t                 upd_o
);

  sgdo_pkg::cell_t              nxt;
  logic [sgdo_pkg::TimeW-1:0]   elapsed;
  logic                         settle;

  always_comb begin
    nxt = cur_i;
    if (raw_i != cur_i.state) begin
      nxt.state  = raw_i;
      nxt.ctime  = now_i;
      nxt.stable = 1'b0;
    end
    // wrapping difference: time running backwards reads as a long hold
    elapsed = now_i - nxt.ctime;
    settle  = elapsed > {{(sgdo_pkg::TimeW - sgdo_pkg::CfgW){1'b0}}, stable_time_i};
    if (settle) begin
      nxt.stable = 1'b1;
    end
    upd_o.entry  = nxt;
    upd_o.settle = settle;
  end

endmodule
